// File: design/rei_pkg.sv
// ----------------------------------------------------------------------------
// rei_pkg: shared types and constants for the ray / ellipsoid intersector
// Fixed-point formats, payload structs, register map and saturation helper.
// ----------------------------------------------------------------------------
package rei_pkg;

  // number format, signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // derived widths
  localparam int RAD_W  = WORD_BITS - 1;      // radius register
  localparam int MAG_W  = WORD_BITS + 1;      // magnitude of origin minus centre
  localparam int NQ_W   = WORD_BITS + 1;      // quotient bits kept before saturation
  localparam int PROD_W = 2 * WORD_BITS;      // dot products, a, b, c
  localparam int BSUM_W = PROD_W + 2;         // signed sum for b
  localparam int H_W    = 4 * WORD_BITS;      // discriminant
  localparam int ROOT_W = 2 * WORD_BITS;      // square root of the discriminant
  localparam int SQR_W  = ROOT_W + 2;         // square root remainder
  localparam int SQT_W  = ROOT_W + 4;         // square root trial value
  localparam int NUMM_W = PROD_W + 1;         // magnitude of -b +/- sqrt(h)
  localparam int NUMS_W = PROD_W + 2;         // signed -b +/- sqrt(h)

  // decoupling queue, depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_X = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_Z = REG_IDX_W'(5);

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] ONE_SQ       = PROD_W'(1) << (2 * FRAC_BITS);

  // one ray per input beat
  typedef struct packed {
    logic signed [WORD_BITS-1:0] origin_x;
    logic signed [WORD_BITS-1:0] origin_y;
    logic signed [WORD_BITS-1:0] origin_z;
    logic signed [WORD_BITS-1:0] dir_x;
    logic signed [WORD_BITS-1:0] dir_y;
    logic signed [WORD_BITS-1:0] dir_z;
  } ray_t;

  // one intersection per output beat
  typedef struct packed {
    logic                        hit;
    logic signed [WORD_BITS-1:0] near_distance;
    logic signed [WORD_BITS-1:0] far_dist;
    logic                        inside_res;
  } isect_t;

  // ellipsoid set-up registers
  typedef struct packed {
    logic signed [WORD_BITS-1:0] center_x;
    logic signed [WORD_BITS-1:0] center_y;
    logic signed [WORD_BITS-1:0] center_z;
    logic [RAD_W-1:0]            radius_x;
    logic [RAD_W-1:0]            radius_y;
    logic [RAD_W-1:0]            radius_z;
  } cfg_t;

  // classified ray handed from front to back
  typedef struct packed {
    logic              miss;
    logic              bneg;
    logic [PROD_W-1:0] bmag;
    logic [PROD_W-1:0] a;
    logic [H_W-1:0]    h;
  } disc_t;

  // sign and magnitude quotient to a saturated signed word
  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic neg, input logic big,
                                                          input logic [NQ_W-1:0] q);
    logic [NQ_W-1:0] lim;
    logic [NQ_W-1:0] v;
    lim = neg ? (NQ_W'(1) << (WORD_BITS - 1)) : ((NQ_W'(1) << (WORD_BITS - 1)) - NQ_W'(1));
    v   = (big || (q > lim)) ? lim : q;
    v   = neg ? (NQ_W'(0) - v) : v;
    return $signed(v[WORD_BITS-1:0]);
  endfunction

endpackage

// File: design/rei_front.sv
// ----------------------------------------------------------------------------
// rei_front: ray set-up and classification
// Moves the ray into ellipsoid space, forms a, b, c and the discriminant, and
// flags rays that cannot hit.
// ----------------------------------------------------------------------------
module rei_front (
  input  logic          clk,
  input  logic          rst,
  input  rei_pkg::cfg_t cfg,
  input  logic          en,
  input  logic          in_valid,
  input  rei_pkg::ray_t in_ray,
  output logic          out_valid,
  output rei_pkg::disc_t out_disc
);
  import rei_pkg::*;

  localparam int NLANE = 6;
  localparam int NAXIS = 3;
  localparam int HI_W  = MAG_W + FRAC_BITS - NQ_W;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [NQ_W-1:0]  rest;
    logic [NQ_W-1:0]  q;
    logic             big;
    logic             neg;
  } ndiv_t;

  // one restoring step of the normalising divide
  function automatic ndiv_t ndiv_step(input ndiv_t s, input logic [RAD_W-1:0] r);
    logic [RAD_W:0] t;
    logic           ge;
    ndiv_t          o;
    t      = {s.rem, s.rest[NQ_W-1]};
    ge     = t >= {1'b0, r};
    o      = s;
    o.rem  = ge ? RAD_W'(t - {1'b0, r}) : RAD_W'(t);
    o.rest = {s.rest[NQ_W-2:0], 1'b0};
    o.q    = {s.q[NQ_W-2:0], ge};
    return o;
  endfunction

  // four partial products into one wide product
  function automatic logic [H_W-1:0] wide_sum(input logic [PROD_W-1:0] ll, lh, hl, hh);
    return H_W'(ll) + (H_W'(lh) << WORD_BITS) + (H_W'(hl) << WORD_BITS) + (H_W'(hh) << PROD_W);
  endfunction

  logic signed [WORD_BITS-1:0] org [NAXIS];
  logic signed [WORD_BITS-1:0] dirv [NAXIS];
  logic signed [WORD_BITS-1:0] cen [NAXIS];
  logic [RAD_W-1:0]            radc [NAXIS];
  logic signed [MAG_W-1:0]     raw [NLANE];

  logic                        v0;
  logic [MAG_W-1:0]            s0_mag [NLANE];
  logic                        s0_neg [NLANE];
  logic [RAD_W-1:0]            s0_rad [NAXIS];

  logic [MAG_W+FRAC_BITS-1:0]  num0 [NLANE];
  logic [HI_W-1:0]             hi0 [NLANE];
  ndiv_t                       init0 [NLANE];

  ndiv_t                       ln [NQ_W+1][NLANE];
  logic [RAD_W-1:0]            lrad [NQ_W+1][NAXIS];
  logic                        lv [NQ_W+1];

  logic                        vn, vm, vs, vc, vp, vw;
  logic signed [WORD_BITS-1:0] nv [NLANE];
  logic signed [PROD_W-1:0]    dd [NAXIS];
  logic signed [PROD_W-1:0]    pp [NAXIS];
  logic signed [PROD_W-1:0]    pd [NAXIS];
  logic [PROD_W-1:0]           s_a, s_c;
  logic signed [BSUM_W-1:0]    s_b;
  logic                        c_azero, c_bneg, c_cmneg;
  logic [PROD_W-1:0]           c_bmag, c_cm, c_a;
  logic [PROD_W-1:0]           pb [4];
  logic [PROD_W-1:0]           pc [4];
  logic                        p_azero, p_bneg, p_cmneg;
  logic [PROD_W-1:0]           p_bmag, p_a;
  logic [H_W-1:0]              w_b2, w_ac;
  logic                        w_azero, w_bneg, w_cmneg;
  logic [PROD_W-1:0]           w_bmag, w_a;

  // origin relative to centre, direction as is
  always_comb begin
    org[0]  = in_ray.origin_x;
    org[1]  = in_ray.origin_y;
    org[2]  = in_ray.origin_z;
    dirv[0] = in_ray.dir_x;
    dirv[1] = in_ray.dir_y;
    dirv[2] = in_ray.dir_z;
    cen[0]  = cfg.center_x;
    cen[1]  = cfg.center_y;
    cen[2]  = cfg.center_z;
    radc[0] = cfg.radius_x;
    radc[1] = cfg.radius_y;
    radc[2] = cfg.radius_z;
    for (int i = 0; i < NAXIS; i++) begin
      raw[i]         = MAG_W'(org[i]) - MAG_W'(cen[i]);
      raw[i + NAXIS] = MAG_W'(dirv[i]);
    end
  end

  // stage 0: sign and magnitude, zero radius reads as one lsb
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NLANE; j++) begin
        s0_neg[j] <= raw[j][MAG_W-1];
        s0_mag[j] <= raw[j][MAG_W-1] ? MAG_W'(-raw[j]) : MAG_W'(raw[j]);
      end
      for (int i = 0; i < NAXIS; i++) begin
        s0_rad[i] <= (radc[i] == '0) ? RAD_W'(1) : radc[i];
      end
    end
  end

  // divider set-up: quotient too large for the kept bits saturates at once
  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      num0[j]       = {s0_mag[j], {FRAC_BITS{1'b0}}};
      hi0[j]        = num0[j][MAG_W+FRAC_BITS-1:NQ_W];
      init0[j].big  = MAG_W'(hi0[j]) >= MAG_W'(s0_rad[j % NAXIS]);
      init0[j].rem  = init0[j].big ? '0 : RAD_W'(hi0[j]);
      init0[j].rest = num0[j][NQ_W-1:0];
      init0[j].q    = '0;
      init0[j].neg  = s0_neg[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NLANE; j++) begin
        ln[0][j] <= init0[j];
      end
      for (int i = 0; i < NAXIS; i++) begin
        lrad[0][i] <= s0_rad[i];
      end
    end
  end

  // divider pipeline, one quotient bit per stage
  genvar k;
  generate
    for (k = 0; k < NQ_W; k++) begin : g_div
      always_ff @(posedge clk) begin
        if (en) begin
          for (int j = 0; j < NLANE; j++) begin
            ln[k+1][j] <= ndiv_step(ln[k][j], lrad[k][j % NAXIS]);
          end
          for (int i = 0; i < NAXIS; i++) begin
            lrad[k+1][i] <= lrad[k][i];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          lv[k+1] <= 1'b0;
        end else if (en) begin
          lv[k+1] <= lv[k];
        end
      end
    end
  endgenerate

  // saturate, products, sums, magnitudes of b and c - 1, partial products, wide products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NLANE; j++) begin
        nv[j] <= sat_word(ln[NQ_W][j].neg, ln[NQ_W][j].big, ln[NQ_W][j].q);
      end
      for (int i = 0; i < NAXIS; i++) begin
        dd[i] <= nv[i + NAXIS] * nv[i + NAXIS];
        pp[i] <= nv[i] * nv[i];
        pd[i] <= nv[i] * nv[i + NAXIS];
      end
      s_a <= $unsigned(dd[0]) + $unsigned(dd[1]) + $unsigned(dd[2]);
      s_c <= $unsigned(pp[0]) + $unsigned(pp[1]) + $unsigned(pp[2]);
      s_b <= BSUM_W'(pd[0]) + BSUM_W'(pd[1]) + BSUM_W'(pd[2]);

      c_azero <= (s_a == '0);
      c_a     <= s_a;
      c_bneg  <= s_b[BSUM_W-1];
      c_bmag  <= s_b[BSUM_W-1] ? PROD_W'(-s_b) : PROD_W'(s_b);
      c_cmneg <= (s_c < ONE_SQ);
      c_cm    <= (s_c < ONE_SQ) ? (ONE_SQ - s_c) : (s_c - ONE_SQ);

      pb[0]   <= c_bmag[WORD_BITS-1:0] * c_bmag[WORD_BITS-1:0];
      pb[1]   <= c_bmag[WORD_BITS-1:0] * c_bmag[PROD_W-1:WORD_BITS];
      pb[2]   <= c_bmag[PROD_W-1:WORD_BITS] * c_bmag[WORD_BITS-1:0];
      pb[3]   <= c_bmag[PROD_W-1:WORD_BITS] * c_bmag[PROD_W-1:WORD_BITS];
      pc[0]   <= c_a[WORD_BITS-1:0] * c_cm[WORD_BITS-1:0];
      pc[1]   <= c_a[WORD_BITS-1:0] * c_cm[PROD_W-1:WORD_BITS];
      pc[2]   <= c_a[PROD_W-1:WORD_BITS] * c_cm[WORD_BITS-1:0];
      pc[3]   <= c_a[PROD_W-1:WORD_BITS] * c_cm[PROD_W-1:WORD_BITS];
      p_azero <= c_azero;
      p_bneg  <= c_bneg;
      p_cmneg <= c_cmneg;
      p_bmag  <= c_bmag;
      p_a     <= c_a;

      w_b2    <= wide_sum(pb[0], pb[1], pb[2], pb[3]);
      w_ac    <= wide_sum(pc[0], pc[1], pc[2], pc[3]);
      w_azero <= p_azero;
      w_bneg  <= p_bneg;
      w_cmneg <= p_cmneg;
      w_bmag  <= p_bmag;
      w_a     <= p_a;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      lv[0] <= 1'b0;
      vn    <= 1'b0;
      vm    <= 1'b0;
      vs    <= 1'b0;
      vc    <= 1'b0;
      vp    <= 1'b0;
      vw    <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      lv[0] <= v0;
      vn    <= lv[NQ_W];
      vm    <= vn;
      vs    <= vm;
      vc    <= vs;
      vp    <= vc;
      vw    <= vp;
    end
  end

  // discriminant and early miss
  always_comb begin
    out_valid     = vw;
    out_disc.miss = w_azero || (!w_cmneg && (w_b2 < w_ac));
    out_disc.bneg = w_bneg;
    out_disc.bmag = w_bmag;
    out_disc.a    = w_a;
    out_disc.h    = w_cmneg ? (w_b2 + w_ac) : (w_b2 - w_ac);
  end

endmodule

// File: design/rei_fifo.sv
// ----------------------------------------------------------------------------
// rei_fifo: decoupling queue between front and back
// Small register queue of classified rays, head read directly.
// ----------------------------------------------------------------------------
module rei_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rei_pkg::disc_t push_data,
  input  logic           pop,
  output rei_pkg::disc_t head,
  output logic           empty,
  output logic           full
);
  import rei_pkg::*;

  disc_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/rei_back.sv
// ----------------------------------------------------------------------------
// rei_back: distance evaluation
// Square root of the discriminant, the two divides by a, saturation and the
// output register.
// ----------------------------------------------------------------------------
module rei_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rei_pkg::disc_t  q_data,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_stall,
  output rei_pkg::isect_t res
);
  import rei_pkg::*;

  localparam int DCMP_W = NUMM_W + FRAC_BITS;
  localparam int DHI_W  = DCMP_W - NQ_W;

  typedef struct packed {
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [H_W-1:0]    rest;
    logic              miss;
    logic              bneg;
    logic [PROD_W-1:0] bmag;
    logic [PROD_W-1:0] a;
  } sq_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [NQ_W-1:0]   rest;
    logic [NQ_W-1:0]   q;
    logic              big;
    logic              neg;
  } qdiv_t;

  // one digit of the integer square root
  function automatic sq_t sq_step(input sq_t s);
    logic [SQT_W-1:0] t;
    logic [SQT_W-1:0] trial;
    logic             ge;
    sq_t              o;
    t      = {s.rem, s.rest[H_W-1 -: 2]};
    trial  = SQT_W'({s.root, 2'b01});
    ge     = t >= trial;
    o      = s;
    o.rem  = ge ? SQR_W'(t - trial) : SQR_W'(t);
    o.rest = {s.rest[H_W-3:0], 2'b00};
    o.root = {s.root[ROOT_W-2:0], ge};
    return o;
  endfunction

  // one restoring step of the distance divide
  function automatic qdiv_t qdiv_step(input qdiv_t s, input logic [PROD_W-1:0] d);
    logic [PROD_W:0] t;
    logic            ge;
    qdiv_t           o;
    t      = {s.rem, s.rest[NQ_W-1]};
    ge     = t >= {1'b0, d};
    o      = s;
    o.rem  = ge ? PROD_W'(t - {1'b0, d}) : PROD_W'(t);
    o.rest = {s.rest[NQ_W-2:0], 1'b0};
    o.q    = {s.q[NQ_W-2:0], ge};
    return o;
  endfunction

  logic                        en;
  sq_t                         sq [ROOT_W+1];
  logic                        sv [ROOT_W+1];
  sq_t                         sq_init;

  logic signed [NUMS_W-1:0]    nb;
  logic signed [NUMS_W-1:0]    nsum [2];
  logic                        nm_valid;
  logic                        nm_neg [2];
  logic [NUMM_W-1:0]           nm_mag [2];
  logic [PROD_W-1:0]           nm_a;
  logic                        nm_miss;

  logic [DCMP_W-1:0]           numv [2];
  logic [DHI_W-1:0]            hiv [2];
  qdiv_t                       dinit [2];
  qdiv_t                       dl [NQ_W+1][2];
  logic [PROD_W-1:0]           da [NQ_W+1];
  logic                        dmiss [NQ_W+1];
  logic                        dv [NQ_W+1];

  logic signed [WORD_BITS-1:0] t_near, t_far;
  logic                        miss_f;

  // the back half moves whenever the output register can take a beat
  assign en    = !res_valid || !res_stall;
  assign q_pop = q_valid && en;

  always_comb begin
    sq_init      = '0;
    sq_init.rest = q_data.h;
    sq_init.miss = q_data.miss;
    sq_init.bneg = q_data.bneg;
    sq_init.bmag = q_data.bmag;
    sq_init.a    = q_data.a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sq_init;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= q_valid;
    end
  end

  // square root pipeline, one root bit per stage
  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_sqrt
      always_ff @(posedge clk) begin
        if (en) begin
          sq[k+1] <= sq_step(sq[k]);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          sv[k+1] <= 1'b0;
        end else if (en) begin
          sv[k+1] <= sv[k];
        end
      end
    end
  endgenerate

  // numerators -b - s and -b + s
  always_comb begin
    nb      = sq[ROOT_W].bneg ? $signed(NUMS_W'(sq[ROOT_W].bmag))
                              : -$signed(NUMS_W'(sq[ROOT_W].bmag));
    nsum[0] = nb - $signed(NUMS_W'(sq[ROOT_W].root));
    nsum[1] = nb + $signed(NUMS_W'(sq[ROOT_W].root));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        nm_neg[j] <= nsum[j][NUMS_W-1];
        nm_mag[j] <= nsum[j][NUMS_W-1] ? NUMM_W'(-nsum[j]) : NUMM_W'(nsum[j]);
      end
      nm_a    <= sq[ROOT_W].a;
      nm_miss <= sq[ROOT_W].miss;
    end
  end

  // divider set-up with early saturation
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      numv[j]       = {nm_mag[j], {FRAC_BITS{1'b0}}};
      hiv[j]        = numv[j][DCMP_W-1:NQ_W];
      dinit[j].big  = DCMP_W'(hiv[j]) >= DCMP_W'(nm_a);
      dinit[j].rem  = dinit[j].big ? '0 : PROD_W'(hiv[j]);
      dinit[j].rest = numv[j][NQ_W-1:0];
      dinit[j].q    = '0;
      dinit[j].neg  = nm_neg[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0][0] <= dinit[0];
      dl[0][1] <= dinit[1];
      da[0]    <= nm_a;
      dmiss[0] <= nm_miss;
    end
  end

  // distance divider pipeline
  generate
    for (k = 0; k < NQ_W; k++) begin : g_div
      always_ff @(posedge clk) begin
        if (en) begin
          dl[k+1][0] <= qdiv_step(dl[k][0], da[k]);
          dl[k+1][1] <= qdiv_step(dl[k][1], da[k]);
          da[k+1]    <= da[k];
          dmiss[k+1] <= dmiss[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[k+1] <= 1'b0;
        end else if (en) begin
          dv[k+1] <= dv[k];
        end
      end
    end
  endgenerate

  // valid through the numerator, set-up and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid  <= 1'b0;
      dv[0]     <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      nm_valid  <= sv[ROOT_W];
      dv[0]     <= nm_valid;
      res_valid <= dv[NQ_W];
    end
  end

  // saturation and final miss on a far point behind the origin
  always_comb begin
    t_near = sat_word(dl[NQ_W][0].neg, dl[NQ_W][0].big, dl[NQ_W][0].q);
    t_far  = sat_word(dl[NQ_W][1].neg, dl[NQ_W][1].big, dl[NQ_W][1].q);
    miss_f = dmiss[NQ_W] || t_far[WORD_BITS-1];
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      res.hit           <= !miss_f;
      res.near_distance <= miss_f ? '0 : t_near;
      res.far_dist      <= miss_f ? '0 : t_far;
      res.inside_res    <= !miss_f && t_near[WORD_BITS-1];
    end
  end

endmodule

// File: design/ray_ellipsoid_intersect.sv
// Throughput: one ray per cycle when neither ray_stall nor res_stall holds the flow;
// the bit-per-stage square root (2*WORD_BITS stages) and the two divider pipelines
// (WORD_BITS+1 stages) set the depth, not the rate.
// A four-beat queue separates classification from evaluation.
// Reset (rst, synchronous) empties the pipelines and queue and loads the
// ellipsoid registers with centre 0 and radii 1.0.
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersect: ray against axis-aligned ellipsoid, fixed point
// Front half classifies each ray, back half gives near and far distances.
// ----------------------------------------------------------------------------
module ray_ellipsoid_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ray_valid,
  output logic                           ray_stall,
  input  rei_pkg::ray_t                  ray,
  output logic                           res_valid,
  input  logic                           res_stall,
  output rei_pkg::isect_t                res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rei_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rei_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rei_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rei_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 f_valid;
  disc_t                f_disc;
  disc_t                q_head;
  logic                 q_empty;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_push;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.center_z <= '0;
      cfg.radius_x <= RADIUS_RESET;
      cfg.radius_y <= RADIUS_RESET;
      cfg.radius_z <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_CENTER_X: cfg.center_x <= WORD_BITS'(pwdata);
        REG_CENTER_Y: cfg.center_y <= WORD_BITS'(pwdata);
        REG_CENTER_Z: cfg.center_z <= WORD_BITS'(pwdata);
        REG_RADIUS_X: cfg.radius_x <= RAD_W'(pwdata);
        REG_RADIUS_Y: cfg.radius_y <= RAD_W'(pwdata);
        REG_RADIUS_Z: cfg.radius_z <= RAD_W'(pwdata);
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = APB_DATA_W'($unsigned(cfg.center_x));
      REG_CENTER_Y: prdata = APB_DATA_W'($unsigned(cfg.center_y));
      REG_CENTER_Z: prdata = APB_DATA_W'($unsigned(cfg.center_z));
      REG_RADIUS_X: prdata = APB_DATA_W'(cfg.radius_x);
      REG_RADIUS_Y: prdata = APB_DATA_W'(cfg.radius_y);
      REG_RADIUS_Z: prdata = APB_DATA_W'(cfg.radius_z);
      default:      prdata = '0;
    endcase
  end

  // front half stalls only on a full queue
  assign ray_stall = q_full;
  assign q_push    = f_valid && !q_full;

  rei_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .en        (!q_full),
    .in_valid  (ray_valid),
    .in_ray    (ray),
    .out_valid (f_valid),
    .out_disc  (f_disc)
  );

  rei_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (f_disc),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rei_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// File: design/rei_checker.sv
// ----------------------------------------------------------------------------
// rei_checker: port-level checks for the intersector
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rei_checker (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_stall,
  input rei_pkg::isect_t res
);
  import rei_pkg::*;

  // nothing comes out straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result beat changed");

  // a miss carries no distances
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.hit) |->
      (res.near_distance == '0 && res.far_dist == '0 && !res.inside_res))
    else $error("miss with non-zero fields");

  // a hit is ordered, its far point ahead of the origin, and inside follows the near sign
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.hit) |->
      ($signed(res.near_distance) <= $signed(res.far_dist) &&
       !res.far_dist[WORD_BITS-1] &&
       res.inside_res == res.near_distance[WORD_BITS-1]))
    else $error("hit distances inconsistent");

endmodule

bind ray_ellipsoid_intersect rei_checker u_rei_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
